// File: rtl/core/lrs_pkg.sv
package lrs_pkg;

   localparam int NUM_LABELS_DEF = 1024;
   localparam int DIFF_BITS_DEF  = 16;

   localparam int CFG_W     = 11;
   localparam int LABEL_W   = 11;
   localparam int IN_DIFF_W = 16;
   localparam int AREA_W    = 32;
   localparam int SUM_W     = 48;
   localparam int SUM_EXT_W = SUM_W + 1;

   localparam logic [CFG_W-1:0] LABEL_COUNT_RST = 11'd1024;

   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic [SUM_W-1:0]  x_sum;
      logic [SUM_W-1:0]  y_sum;
   } stat_entry_type;

   // add a sign-extended difference to a sum, clamp at the 48-bit signed limits
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [SUM_EXT_W-1:0] d);
      logic [SUM_EXT_W-1:0] r;
      logic [SUM_W-1:0]     res;
      r = {s[SUM_W-1], s} + d;
      if (r[SUM_EXT_W-1] != r[SUM_W-1]) begin
         res = {r[SUM_EXT_W-1], {(SUM_W-1){~r[SUM_EXT_W-1]}}};
      end else begin
         res = r[SUM_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/core/lrs_if.sv
interface lrs_req_if;
   import lrs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [LABEL_W-1:0]          label;
   logic signed [IN_DIFF_W-1:0] x_diff;
   logic signed [IN_DIFF_W-1:0] y_diff;

   modport source (output valid, cmd, label, x_diff, y_diff, input ready);
   modport sink   (input valid, cmd, label, x_diff, y_diff, output ready);
endinterface

interface lrs_rsp_if;
   import lrs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    in_range;
   logic [AREA_W-1:0]       area;
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;

   modport source (output valid, in_range, area, x_sum, y_sum, input ready);
   modport sink   (input valid, in_range, area, x_sum, y_sum, output ready);
endinterface

// File: rtl/core/lrs_stat_mem.sv
module lrs_stat_mem #(
   parameter int DEPTH = lrs_pkg::NUM_LABELS_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_idx,
   input  lrs_pkg::stat_entry_type      wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_idx,
   output lrs_pkg::stat_entry_type      rd_data
);
   import lrs_pkg::*;

   stat_entry_type mem [DEPTH];
   stat_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // read returns the old entry when the same address is written in that cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/label_region_statistics_unit.sv
// channel | direction | beat contents
// req_ch  | in        | cmd, label, x_diff, y_diff
// rsp_ch  | out       | in_range, area, x_sum, y_sum (one beat per read command)
// csr     | in        | label_count, written when csr_wr_en is high
//
// Takes one beat per cycle when not held off: the label store is a single-port-read,
// single-port-write memory with a registered read, and the write-back of an entry is
// forwarded to the beat right behind it when both carry the same label.
// After reset all NUM_LABELS entries are cleared, one entry a cycle, with req_ch
// not ready. A read beat waits in the update stage while the response register is
// full and not taken, and holds off req_ch for those cycles.
module label_region_statistics_unit #(
   parameter int NUM_LABELS = lrs_pkg::NUM_LABELS_DEF,
   parameter int DIFF_BITS  = lrs_pkg::DIFF_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [lrs_pkg::CFG_W-1:0] csr_wr_data,
   lrs_req_if.sink                   req_ch,
   lrs_rsp_if.source                 rsp_ch
);
   import lrs_pkg::*;

   localparam int IDX_W = $clog2(NUM_LABELS);

   logic [CFG_W-1:0] label_count_ff;

   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_cmd_ff;
   logic                 s1_ok_ff;
   logic                 s1_hit_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [DIFF_BITS-1:0] s1_xd_ff, s1_yd_ff;

   stat_entry_type last_wr_ff;

   logic           out_valid_ff, out_valid_in;
   stat_entry_type out_data_ff;
   logic           out_range_ff;

   logic                 accept, s1_adv, s1_stall, s1_wr;
   logic                 lbl_ok;
   logic [IDX_W-1:0]     idx0;
   logic [31:0]          xw, yw;
   stat_entry_type       rd_data, cur, upd, wr_data;
   logic [SUM_EXT_W-1:0] xd_ext, yd_ext;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff <= LABEL_COUNT_RST;
      end else if (csr_wr_en) begin
         label_count_ff <= csr_wr_data;
      end
   end

   // clearing pass after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(NUM_LABELS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // handshake
   assign s1_adv   = s1_valid_ff &&
                     !(s1_cmd_ff == CMD_READ && out_valid_ff && !rsp_ch.ready);
   assign s1_stall = s1_valid_ff && !s1_adv;
   assign s1_wr    = s1_adv && s1_ok_ff;
   assign req_ch.ready = !clr_busy_ff && !s1_stall;
   assign accept   = req_ch.valid && req_ch.ready;

   assign lbl_ok = (req_ch.label != '0) && (req_ch.label <= label_count_ff) &&
                   (32'(req_ch.label) <= 32'(NUM_LABELS));
   assign idx0   = IDX_W'(req_ch.label - 11'd1);
   assign xw     = {16'b0, req_ch.x_diff};
   assign yw     = {16'b0, req_ch.y_diff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req_ch.cmd;
         s1_ok_ff  <= lbl_ok;
         s1_idx_ff <= idx0;
         s1_xd_ff  <= xw[DIFF_BITS-1:0];
         s1_yd_ff  <= yw[DIFF_BITS-1:0];
         // the memory read in this cycle misses the write-back happening now
         s1_hit_ff <= s1_wr && (s1_idx_ff == idx0);
      end
   end

   lrs_stat_mem #(
      .DEPTH (NUM_LABELS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (clr_busy_ff || s1_wr),
      .wr_idx  (clr_busy_ff ? clr_idx_ff : s1_idx_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_idx  (idx0),
      .rd_data (rd_data)
   );

   // update stage
   assign cur    = s1_hit_ff ? last_wr_ff : rd_data;
   assign xd_ext = {{(SUM_EXT_W-DIFF_BITS){s1_xd_ff[DIFF_BITS-1]}}, s1_xd_ff};
   assign yd_ext = {{(SUM_EXT_W-DIFF_BITS){s1_yd_ff[DIFF_BITS-1]}}, s1_yd_ff};

   always_comb begin
      upd = '0;
      if (s1_cmd_ff == CMD_ACCUM) begin
         upd.area  = (&cur.area) ? cur.area : cur.area + 1'b1;
         upd.x_sum = sat_add(cur.x_sum, xd_ext);
         upd.y_sum = sat_add(cur.y_sum, yd_ext);
      end
   end

   assign wr_data = clr_busy_ff ? '0 : upd;

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         last_wr_ff <= upd;
      end
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_cmd_ff == CMD_READ) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_cmd_ff == CMD_READ) begin
         out_range_ff <= s1_ok_ff;
         out_data_ff  <= s1_ok_ff ? cur : '0;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.in_range = out_range_ff;
   assign rsp_ch.area     = out_data_ff.area;
   assign rsp_ch.x_sum    = out_data_ff.x_sum;
   assign rsp_ch.y_sum    = out_data_ff.y_sum;

endmodule

// File: rtl/core/lrs_checker.sv
module lrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_in_range,
   input logic [lrs_pkg::AREA_W-1:0]       rsp_area,
   input logic signed [lrs_pkg::SUM_W-1:0] rsp_x_sum,
   input logic signed [lrs_pkg::SUM_W-1:0] rsp_y_sum
);
   import lrs_pkg::*;

   // store clearing keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready during store clearing");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |->
         (rsp_area == '0 && rsp_x_sum == '0 && rsp_y_sum == '0))
      else $error("out-of-range read returned nonzero statistics");

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         $stable({rsp_in_range, rsp_area, rsp_x_sum, rsp_y_sum}))
      else $error("response payload changed while stalled");

endmodule

bind label_region_statistics_unit lrs_checker u_lrs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_in_range (rsp_ch.in_range),
   .rsp_area     (rsp_ch.area),
   .rsp_x_sum    (rsp_ch.x_sum),
   .rsp_y_sum    (rsp_ch.y_sum)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

import lrs_pkg::*;

typedef struct {
   logic              in_range;
   logic [AREA_W-1:0] area;
   logic [SUM_W-1:0]  x_sum;
   logic [SUM_W-1:0]  y_sum;
} label_stats_type;

// per-label area and difference sums, kept alongside the block
class label_stats_board;
   int unsigned  label_count = LABEL_COUNT_RST;
   bit [AREA_W-1:0] area_tab [NUM_LABELS_DEF];
   longint       x_tab [NUM_LABELS_DEF];
   longint       y_tab [NUM_LABELS_DEF];
   label_stats_type pending_reads [$];
   int           mismatches;
   int           accum_beats;
   int           read_beats;
   int           outside_reads;

   function longint clamp_sum(longint s, longint d);
      longint r;
      r = s + d;
      if (r > 64'sh0000_7FFF_FFFF_FFFF) begin
         r = 64'sh0000_7FFF_FFFF_FFFF;
      end else if (r < -64'sh0000_8000_0000_0000) begin
         r = -64'sh0000_8000_0000_0000;
      end
      return r;
   endfunction

   function void note_request(logic cmd, logic [LABEL_W-1:0] label,
                              logic [IN_DIFF_W-1:0] xd, logic [IN_DIFF_W-1:0] yd);
      int unsigned  lim;
      int           idx;
      bit           hit;
      label_stats_type e;
      lim = (label_count > NUM_LABELS_DEF) ? NUM_LABELS_DEF : label_count;
      hit = (label >= 1) && (label <= lim);
      idx = int'(label) - 1;
      if (cmd == CMD_ACCUM) begin
         accum_beats++;
         if (hit) begin
            if (area_tab[idx] != '1) begin
               area_tab[idx]++;
            end
            x_tab[idx] = clamp_sum(x_tab[idx], longint'($signed(xd)));
            y_tab[idx] = clamp_sum(y_tab[idx], longint'($signed(yd)));
         end
      end else begin
         read_beats++;
         e.in_range = hit;
         if (hit) begin
            e.area  = area_tab[idx];
            e.x_sum = x_tab[idx][SUM_W-1:0];
            e.y_sum = y_tab[idx][SUM_W-1:0];
            area_tab[idx] = '0;
            x_tab[idx]    = 0;
            y_tab[idx]    = 0;
         end else begin
            outside_reads++;
            e.area  = '0;
            e.x_sum = '0;
            e.y_sum = '0;
         end
         pending_reads.push_back(e);
      end
   endfunction

   function void check_response(label_stats_type got);
      label_stats_type want;
      if (pending_reads.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected response beat: in_range=%0b area=%0d x=%0d y=%0d",
                     got.in_range, got.area, $signed(got.x_sum), $signed(got.y_sum));
         end
         return;
      end
      want = pending_reads.pop_front();
      if (got.in_range !== want.in_range || got.area !== want.area ||
          got.x_sum !== want.x_sum || got.y_sum !== want.y_sum) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response mismatch: expected in_range=%0b area=%0d x=%0d y=%0d",
                     want.in_range, want.area, $signed(want.x_sum), $signed(want.y_sum));
            $display("                   actual   in_range=%0b area=%0d x=%0d y=%0d",
                     got.in_range, got.area, $signed(got.x_sum), $signed(got.y_sum));
         end
      end
   endfunction
endclass

module testbench;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_BEATS = 200;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   lrs_req_if req_ch();
   lrs_rsp_if rsp_ch();

   label_region_statistics_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   label_stats_board board = new;
   int send_idle_pct = 17;
   int recv_idle_pct = 85;
   int settings_seen;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_beat(logic cmd, logic [LABEL_W-1:0] label,
                            logic [IN_DIFF_W-1:0] xd, logic [IN_DIFF_W-1:0] yd);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.cmd    <= cmd;
      req_ch.label  <= label;
      req_ch.x_diff <= xd;
      req_ch.y_diff <= yd;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_request(cmd, label, xd, yd);
   endtask

   // drives the request channel quiet and waits until every read is answered first
   task automatic write_label_count(logic [CFG_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (board.pending_reads.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.label_count = value;
      settings_seen++;
   endtask

   function automatic logic [LABEL_W-1:0] pick_label(int unsigned lim);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 12) begin
         return LABEL_W'($urandom_range(0, 2047));
      end else if (r < 18) begin
         return '0;
      end else if (r < 24) begin
         return LABEL_W'($urandom_range(lim + 1, 2047));
      end else if (r < 70) begin
         // a few hot labels so entries collide, often back to back
         return LABEL_W'($urandom_range(1, (lim < 4) ? lim : 4));
      end
      return LABEL_W'($urandom_range(1, lim));
   endfunction

   function automatic logic [IN_DIFF_W-1:0] pick_diff();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h7FFF;
      if (r < 20) return 16'h8000;
      if (r < 30) return IN_DIFF_W'($urandom_range(0, 16) - 8);
      return IN_DIFF_W'($urandom);
   endfunction

   task automatic random_phase(int beats);
      int unsigned lim;
      lim = (board.label_count > NUM_LABELS_DEF) ? NUM_LABELS_DEF : board.label_count;
      repeat (beats) begin
         send_beat(($urandom_range(0, 99) < 25) ? CMD_READ : CMD_ACCUM,
                   pick_label(lim), pick_diff(), pick_diff());
      end
   endtask

   // response side: random backpressure, every beat checked
   initial begin
      label_stats_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.in_range = rsp_ch.in_range;
            got.area     = rsp_ch.area;
            got.x_sum    = rsp_ch.x_sum;
            got.y_sum    = rsp_ch.y_sum;
            board.check_response(got);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] settings [6];
      int failures;
      settings = '{11'd16, 11'd1, 11'd1024, 11'd0, 11'd2047, 11'd0};
      settings[5] = CFG_W'($urandom_range(2, 1024));

      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_ACCUM;
      req_ch.label <= '0;
      req_ch.x_diff <= '0;
      req_ch.y_diff <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset label_count
      send_beat(CMD_ACCUM, 11'd1, 16'h7FFF, 16'h8000);
      send_beat(CMD_ACCUM, 11'd1, 16'h8000, 16'h7FFF);
      send_beat(CMD_ACCUM, 11'd1, 16'hFFFF, 16'h0001);
      send_beat(CMD_READ,  11'd1, 16'h0000, 16'h0000);
      send_beat(CMD_READ,  11'd1, 16'h0000, 16'h0000);
      send_beat(CMD_ACCUM, 11'd1024, 16'h5555, 16'hAAAA);
      send_beat(CMD_ACCUM, 11'd1024, 16'hAAAA, 16'h5555);
      send_beat(CMD_READ,  11'd1024, 16'h0000, 16'h0000);
      send_beat(CMD_ACCUM, 11'd0, 16'h1234, 16'h4321);
      send_beat(CMD_READ,  11'd0, 16'h0000, 16'h0000);
      send_beat(CMD_ACCUM, 11'd1025, 16'h7FFF, 16'h7FFF);
      send_beat(CMD_READ,  11'd1025, 16'h0000, 16'h0000);
      send_beat(CMD_READ,  11'd2047, 16'hFFFF, 16'hFFFF);
      send_beat(CMD_READ,  11'd500, 16'h0000, 16'h0000);
      // same label back to back, read right behind the last write
      send_beat(CMD_ACCUM, 11'd2, 16'h8000, 16'h8000);
      send_beat(CMD_ACCUM, 11'd2, 16'h8000, 16'h8000);
      send_beat(CMD_ACCUM, 11'd2, 16'h8000, 16'h8000);
      send_beat(CMD_READ,  11'd2, 16'h0000, 16'h0000);
      send_beat(CMD_ACCUM, 11'd3, 16'h7FFF, 16'h0000);
      send_beat(CMD_READ,  11'd3, 16'h0000, 16'h0000);
      send_beat(CMD_ACCUM, 11'd3, 16'h0000, 16'h7FFF);
      send_beat(CMD_READ,  11'd3, 16'h0000, 16'h0000);

      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            send_idle_pct = 85;
            recv_idle_pct = 17;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_label_count(settings[p]);
         random_phase(PHASE_BEATS);
      end
      req_ch.valid <= 1'b0;

      while (board.pending_reads.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      failures = board.mismatches + board.pending_reads.size();
      $display("%0d accumulate and %0d read beats, %0d of the reads outside the label range,",
               board.accum_beats, board.read_beats, board.outside_reads);
      $display("over %0d label_count settings besides reset, %0d mismatches",
               settings_seen, board.mismatches);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: label_region_statistics_unit.f
rtl/core/lrs_pkg.sv
rtl/core/lrs_if.sv
rtl/core/lrs_stat_mem.sv
rtl/core/label_region_statistics_unit.sv
rtl/core/lrs_checker.sv
test/testbench.sv
